[design/iasq_pkg.sv]
// Shared types and constants for the intrusion alarm sequencer.
package iasq_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_THRESHOLD  = 4'd0;
  localparam logic [3:0] CFG_SWEEP_MIN  = 4'd1;
  localparam logic [3:0] CFG_SWEEP_MAX  = 4'd2;
  localparam logic [3:0] CFG_SWEEP_STEP = 4'd3;
  localparam logic [3:0] CFG_SWEEP_IVL  = 4'd4;
  localparam logic [3:0] CFG_PREALARM   = 4'd5;
  localparam logic [3:0] CFG_LOST       = 4'd6;
  localparam logic [3:0] CFG_PATTERN    = 4'd7;

  // Tone command codes
  localparam logic [2:0] TONE_NONE    = 3'd0;
  localparam logic [2:0] TONE_PLAY    = 3'd1;
  localparam logic [2:0] TONE_BEEP    = 3'd2;
  localparam logic [2:0] TONE_TWO     = 3'd3;
  localparam logic [2:0] TONE_SILENCE = 3'd4;

  // Siren patterns
  localparam logic [1:0] PAT_SWEEP = 2'd1;
  localparam logic [1:0] PAT_CHIRP = 2'd2;
  localparam logic [1:0] PAT_DUAL  = 2'd3;

  // Distance check: 17 / 1000 scale
  localparam logic [19:0] ECHO_SCALE  = 20'd17;
  localparam logic [19:0] DIST_SCALE  = 20'd1000;

  // Pre-alarm beeps
  localparam logic [11:0] BEEP_TONE_INIT = 12'd3200;
  localparam logic [11:0] BEEP_TONE_MIN  = 12'd900;
  localparam logic [11:0] BEEP_TONE_STEP = 12'd200;
  localparam logic [9:0]  BEEP_GAP_INIT  = 10'd600;
  localparam logic [9:0]  BEEP_GAP_MIN   = 10'd120;
  localparam logic [9:0]  BEEP_GAP_STEP  = 10'd60;
  localparam logic [5:0]  BEEP_PULSE     = 6'd60;

  // Siren sweep
  localparam logic [11:0] SWEEP_FREQ_INIT = 12'd2600;
  localparam logic [11:0] SWEEP_FREQ_STEP = 12'd140;
  localparam logic [11:0] SWEEP_FREQ_HI   = 12'd3800;
  localparam logic [11:0] SWEEP_FREQ_LO   = 12'd2200;
  localparam int unsigned SWEEP_GAP_MS    = 40;

  // Siren chirp
  localparam logic [11:0] CHIRP_FREQ     = 12'd3500;
  localparam logic [11:0] CHIRP_FREQ_END = 12'd900;
  localparam logic [5:0]  CHIRP_PULSE    = 6'd20;
  localparam int unsigned CHIRP_GAP_MS   = 120;

  // Siren two-tone
  localparam logic [11:0] DUAL_FREQ_HI = 12'd3600;
  localparam logic [11:0] DUAL_FREQ_LO = 12'd2400;
  localparam int unsigned DUAL_GAP_MS  = 80;

  // Servo
  localparam logic [7:0] ANGLE_INIT = 8'd90;
  localparam logic [9:0] ANGLE_MAX  = 10'd180;

  // Result queue depth between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef struct packed {
    logic [8:0]  threshold;
    logic [7:0]  sweep_min;
    logic [7:0]  sweep_max;
    logic [5:0]  sweep_step;
    logic [15:0] sweep_ivl;
    logic [15:0] prealarm_ms;
    logic [15:0] lost_ms;
    logic [15:0] pattern_ms;
  } cfg_regs_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [31:0] now_ms;
    logic        detect;
  } qent_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] freq;
    logic [11:0] freq_after;
    logic [5:0]  pulse;
  } tone_t;

endpackage

[design/iasq_queue.sv]
// Short queue of classified items between the front and the back.
module iasq_queue import iasq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output qent_t rdata,
  output logic  empty
);

  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= wdata;
  end

endmodule

[design/iasq_front.sv]
// Front end: accepts items and classifies the echo as detection or not.
module iasq_front import iasq_pkg::*; (
  input  logic        push,
  input  logic [31:0] in_now_ms,
  input  logic [14:0] in_echo_us,
  input  logic [8:0]  threshold,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_data
);

  logic [19:0] echo_scaled;
  logic [19:0] thr_scaled;

  // floor(echo*17/1000) in [1, thr) is echo*17 in [1000, thr*1000)
  assign echo_scaled = {5'b0, in_echo_us} * ECHO_SCALE;
  assign thr_scaled  = {11'b0, threshold} * DIST_SCALE;

  assign q_push        = push && !q_full;
  assign q_data.now_ms = in_now_ms;
  assign q_data.detect = (in_echo_us != '0) && (echo_scaled >= DIST_SCALE) &&
                         (echo_scaled < thr_scaled);

endmodule

[design/iasq_back.sv]
// Back end: alarm sequencer state and the result buffer that drains one result a pop.
module iasq_back import iasq_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_regs_t   cfg,
  input  logic        q_empty,
  input  qent_t       q_data,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic        out_red_led,
  output logic [7:0]  out_servo_angle,
  output logic        out_servo_moved,
  output logic [2:0]  out_tone_cmd,
  output logic [11:0] out_tone_freq,
  output logic [11:0] out_tone_freq_after,
  output logic [5:0]  out_pulse_ms,
  output logic        out_last
);

  typedef logic [TIME_BITS-1:0] tm_t;

  function automatic tm_t elapsed(input tm_t a, input tm_t b);
    return a - b;
  endfunction

  // Sequencer state
  logic        prealarm_r, prealarm_nxt;
  logic        alarm_r, alarm_nxt;
  tm_t         last_seen_r, last_seen_nxt;
  tm_t         pre_start_r, pre_start_nxt;
  tm_t         last_beep_r, last_beep_nxt;
  logic [11:0] beep_tone_r, beep_tone_nxt;
  logic [9:0]  beep_gap_r, beep_gap_nxt;
  logic [1:0]  pattern_r, pattern_nxt;
  tm_t         pat_switch_r, pat_switch_nxt;
  tm_t         last_sound_r, last_sound_nxt;
  logic [11:0] sweep_freq_r, sweep_freq_nxt;
  logic        rising_r, rising_nxt;
  logic        dual_hi_r, dual_hi_nxt;
  logic [7:0]  angle_r, angle_nxt;
  logic        down_r, down_nxt;
  tm_t         last_servo_r, last_servo_nxt;

  // Result buffer
  logic        buf_valid_r;
  logic        buf_led_r, buf_moved_r;
  logic [7:0]  buf_angle_r;
  tone_t       buf_tone_r [3];
  logic [1:0]  buf_cnt_r, buf_idx_r;

  // Per-item combinational results
  tm_t         now;
  tm_t         since;
  logic        led, moved;
  logic [1:0]  n;
  tone_t       tones [3];
  logic signed [9:0] ang_sum;
  logic        load, buf_last;

  assign buf_last = (buf_idx_r == buf_cnt_r - 2'd1);
  assign load     = !q_empty && (!buf_valid_r || (pop && buf_last));
  assign q_pop    = load;

  // Evaluate one item against the current state
  always_comb begin
    now            = TIME_BITS'(q_data.now_ms);
    since          = '0;
    prealarm_nxt   = prealarm_r;
    alarm_nxt      = alarm_r;
    last_seen_nxt  = last_seen_r;
    pre_start_nxt  = pre_start_r;
    last_beep_nxt  = last_beep_r;
    beep_tone_nxt  = beep_tone_r;
    beep_gap_nxt   = beep_gap_r;
    pattern_nxt    = pattern_r;
    pat_switch_nxt = pat_switch_r;
    last_sound_nxt = last_sound_r;
    sweep_freq_nxt = sweep_freq_r;
    rising_nxt     = rising_r;
    dual_hi_nxt    = dual_hi_r;
    angle_nxt      = angle_r;
    down_nxt       = down_r;
    last_servo_nxt = last_servo_r;
    moved          = 1'b0;
    ang_sum        = '0;
    n              = '0;
    for (int i = 0; i < 3; i++) tones[i] = '0;

    // Detection
    if (q_data.detect) begin
      last_seen_nxt = now;
      if (!prealarm_r && !alarm_r) begin
        prealarm_nxt  = 1'b1;
        pre_start_nxt = now;
        beep_tone_nxt = BEEP_TONE_INIT;
        beep_gap_nxt  = BEEP_GAP_INIT;
      end
    end
    led = prealarm_nxt || alarm_nxt;

    // Pre-alarm beeps and hand-over to the siren
    if (prealarm_nxt) begin
      if (elapsed(now, last_beep_nxt) > TIME_BITS'(beep_gap_nxt)) begin
        tones[n] = '{cmd: TONE_BEEP, freq: beep_tone_nxt, freq_after: '0, pulse: BEEP_PULSE};
        n = n + 2'd1;
        if (beep_tone_nxt > BEEP_TONE_MIN) beep_tone_nxt = beep_tone_nxt - BEEP_TONE_STEP;
        if (beep_gap_nxt > BEEP_GAP_MIN) beep_gap_nxt = beep_gap_nxt - BEEP_GAP_STEP;
        last_beep_nxt = now;
      end
      if (elapsed(now, pre_start_nxt) > TIME_BITS'(cfg.prealarm_ms)) begin
        prealarm_nxt   = 1'b0;
        alarm_nxt      = 1'b1;
        pattern_nxt    = PAT_SWEEP;
        pat_switch_nxt = now;
        sweep_freq_nxt = SWEEP_FREQ_INIT;
        rising_nxt     = 1'b1;
      end
    end

    // Siren patterns
    if (alarm_nxt) begin
      if (elapsed(now, pat_switch_nxt) > TIME_BITS'(cfg.pattern_ms)) begin
        pattern_nxt    = (pattern_nxt >= PAT_DUAL) ? PAT_SWEEP : pattern_nxt + 2'd1;
        pat_switch_nxt = now;
      end
      since = elapsed(now, last_sound_nxt);
      if (pattern_nxt == PAT_SWEEP && since > TIME_BITS'(SWEEP_GAP_MS)) begin
        sweep_freq_nxt = rising_nxt ? sweep_freq_nxt + SWEEP_FREQ_STEP
                                    : sweep_freq_nxt - SWEEP_FREQ_STEP;
        if (sweep_freq_nxt >= SWEEP_FREQ_HI) rising_nxt = 1'b0;
        if (sweep_freq_nxt <= SWEEP_FREQ_LO) rising_nxt = 1'b1;
        tones[n] = '{cmd: TONE_PLAY, freq: sweep_freq_nxt, freq_after: '0, pulse: '0};
        n = n + 2'd1;
        last_sound_nxt = now;
      end else if (pattern_nxt == PAT_CHIRP && since > TIME_BITS'(CHIRP_GAP_MS)) begin
        tones[n] = '{cmd: TONE_TWO, freq: CHIRP_FREQ, freq_after: CHIRP_FREQ_END,
                     pulse: CHIRP_PULSE};
        n = n + 2'd1;
        last_sound_nxt = now;
      end else if (pattern_nxt == PAT_DUAL && since > TIME_BITS'(DUAL_GAP_MS)) begin
        tones[n] = '{cmd: TONE_PLAY, freq: dual_hi_nxt ? DUAL_FREQ_HI : DUAL_FREQ_LO,
                     freq_after: '0, pulse: '0};
        n = n + 2'd1;
        dual_hi_nxt    = !dual_hi_nxt;
        last_sound_nxt = now;
      end
    end

    // Servo sweep while idle
    if (!prealarm_nxt && !alarm_nxt) begin
      if (elapsed(now, last_servo_nxt) > TIME_BITS'(cfg.sweep_ivl)) begin
        ang_sum = down_nxt ? $signed({2'b00, angle_nxt}) - $signed({4'b0000, cfg.sweep_step})
                           : $signed({2'b00, angle_nxt}) + $signed({4'b0000, cfg.sweep_step});
        if (ang_sum < 0) ang_sum = '0;
        if (ang_sum > $signed(ANGLE_MAX)) ang_sum = $signed(ANGLE_MAX);
        angle_nxt = ang_sum[7:0];
        if (angle_nxt >= cfg.sweep_max) down_nxt = 1'b1;
        if (angle_nxt <= cfg.sweep_min) down_nxt = 1'b0;
        last_servo_nxt = now;
        moved          = 1'b1;
      end
    end

    // Target lost: clear everything
    if ((prealarm_nxt || alarm_nxt) &&
        elapsed(now, last_seen_nxt) > TIME_BITS'(cfg.lost_ms)) begin
      prealarm_nxt = 1'b0;
      alarm_nxt    = 1'b0;
      tones[n]     = '{cmd: TONE_SILENCE, freq: '0, freq_after: '0, pulse: '0};
      n = n + 2'd1;
    end

    if (n == '0) begin
      tones[0] = '{cmd: TONE_NONE, freq: '0, freq_after: '0, pulse: '0};
      n = 2'd1;
    end
  end

  // State update on each loaded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prealarm_r   <= 1'b0;
      alarm_r      <= 1'b0;
      last_seen_r  <= '0;
      pre_start_r  <= '0;
      last_beep_r  <= '0;
      beep_tone_r  <= BEEP_TONE_INIT;
      beep_gap_r   <= BEEP_GAP_INIT;
      pattern_r    <= PAT_SWEEP;
      pat_switch_r <= '0;
      last_sound_r <= '0;
      sweep_freq_r <= SWEEP_FREQ_INIT;
      rising_r     <= 1'b1;
      dual_hi_r    <= 1'b1;
      angle_r      <= ANGLE_INIT;
      down_r       <= 1'b0;
      last_servo_r <= '0;
    end else if (load) begin
      prealarm_r   <= prealarm_nxt;
      alarm_r      <= alarm_nxt;
      last_seen_r  <= last_seen_nxt;
      pre_start_r  <= pre_start_nxt;
      last_beep_r  <= last_beep_nxt;
      beep_tone_r  <= beep_tone_nxt;
      beep_gap_r   <= beep_gap_nxt;
      pattern_r    <= pattern_nxt;
      pat_switch_r <= pat_switch_nxt;
      last_sound_r <= last_sound_nxt;
      sweep_freq_r <= sweep_freq_nxt;
      rising_r     <= rising_nxt;
      dual_hi_r    <= dual_hi_nxt;
      angle_r      <= angle_nxt;
      down_r       <= down_nxt;
      last_servo_r <= last_servo_nxt;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      buf_idx_r   <= '0;
    end else if (load) begin
      buf_valid_r <= 1'b1;
      buf_idx_r   <= '0;
    end else if (pop && buf_valid_r) begin
      if (buf_last) buf_valid_r <= 1'b0;
      else          buf_idx_r   <= buf_idx_r + 2'd1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (load) begin
      buf_led_r   <= led;
      buf_moved_r <= moved;
      buf_angle_r <= angle_nxt;
      buf_cnt_r   <= n;
      for (int i = 0; i < 3; i++) buf_tone_r[i] <= tones[i];
    end
  end

  assign empty               = !buf_valid_r;
  assign out_red_led         = buf_led_r;
  assign out_servo_angle     = buf_angle_r;
  assign out_servo_moved     = buf_moved_r;
  assign out_tone_cmd        = buf_tone_r[buf_idx_r].cmd;
  assign out_tone_freq       = buf_tone_r[buf_idx_r].freq;
  assign out_tone_freq_after = buf_tone_r[buf_idx_r].freq_after;
  assign out_pulse_ms        = buf_tone_r[buf_idx_r].pulse;
  assign out_last            = buf_last;

endmodule

[design/intrusion_alarm_sequencer_core.sv]
// An accepted item passes through the queue and then the result buffer before it shows.
// Throughput: one item per cycle while the queue is not full; an item with n results
// holds the output for n pops, set by the single result buffer that drains one result
// per pop. A four-entry queue lets the front keep accepting while results wait.
// Synchronous active-low reset loads control and sequencer state to defaults.
module intrusion_alarm_sequencer_core import iasq_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_now_ms,
  input  logic [14:0] in_echo_us,
  output logic        empty,
  input  logic        pop,
  output logic        out_red_led,
  output logic [7:0]  out_servo_angle,
  output logic        out_servo_moved,
  output logic [2:0]  out_tone_cmd,
  output logic [11:0] out_tone_freq,
  output logic [11:0] out_tone_freq_after,
  output logic [5:0]  out_pulse_ms,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t cfg_r;
  logic      q_push, q_full, q_pop, q_empty;
  qent_t     q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= 9'd25;
      cfg_r.sweep_min   <= 8'd30;
      cfg_r.sweep_max   <= 8'd150;
      cfg_r.sweep_step  <= 6'd2;
      cfg_r.sweep_ivl   <= 16'd25;
      cfg_r.prealarm_ms <= 16'd4000;
      cfg_r.lost_ms     <= 16'd1500;
      cfg_r.pattern_ms  <= 16'd5000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD:  cfg_r.threshold   <= cfg_data[8:0];
        CFG_SWEEP_MIN:  cfg_r.sweep_min   <= cfg_data[7:0];
        CFG_SWEEP_MAX:  cfg_r.sweep_max   <= cfg_data[7:0];
        CFG_SWEEP_STEP: cfg_r.sweep_step  <= cfg_data[5:0];
        CFG_SWEEP_IVL:  cfg_r.sweep_ivl   <= cfg_data;
        CFG_PREALARM:   cfg_r.prealarm_ms <= cfg_data;
        CFG_LOST:       cfg_r.lost_ms     <= cfg_data;
        CFG_PATTERN:    cfg_r.pattern_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  iasq_front u_front (
    .push       (push),
    .in_now_ms  (in_now_ms),
    .in_echo_us (in_echo_us),
    .threshold  (cfg_r.threshold),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  assign full = q_full;

  iasq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  iasq_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_empty             (q_empty),
    .q_data              (q_rdata),
    .q_pop               (q_pop),
    .pop                 (pop),
    .empty               (empty),
    .out_red_led         (out_red_led),
    .out_servo_angle     (out_servo_angle),
    .out_servo_moved     (out_servo_moved),
    .out_tone_cmd        (out_tone_cmd),
    .out_tone_freq       (out_tone_freq),
    .out_tone_freq_after (out_tone_freq_after),
    .out_pulse_ms        (out_pulse_ms),
    .out_last            (out_last)
  );

endmodule

[bench/testbench.sv]
// Self-checking testbench for the intrusion alarm sequencer core.
`timescale 1ns / 100ps

module testbench import iasq_pkg::*;;

  // Indexes past the last register, which the block must ignore
  localparam logic [3:0] CFG_UNUSED_LO = 4'd8;
  localparam logic [3:0] CFG_UNUSED_HI = 4'd15;
  localparam int HOLD_CYCLES = 200;

  // One result item as it leaves the block
  typedef struct packed {
    logic        red;
    logic [7:0]  angle;
    logic        moved;
    logic [2:0]  cmd;
    logic [11:0] freq;
    logic [11:0] freq_after;
    logic [5:0]  pulse;
    logic        last;
  } alarm_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_now_ms = '0;
  logic [14:0] in_echo_us = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_red_led;
  logic [7:0]  out_servo_angle;
  logic        out_servo_moved;
  logic [2:0]  out_tone_cmd;
  logic [11:0] out_tone_freq;
  logic [11:0] out_tone_freq_after;
  logic [5:0]  out_pulse_ms;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  intrusion_alarm_sequencer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_now_ms           (in_now_ms),
    .in_echo_us          (in_echo_us),
    .empty               (empty),
    .pop                 (pop),
    .out_red_led         (out_red_led),
    .out_servo_angle     (out_servo_angle),
    .out_servo_moved     (out_servo_moved),
    .out_tone_cmd        (out_tone_cmd),
    .out_tone_freq       (out_tone_freq),
    .out_tone_freq_after (out_tone_freq_after),
    .out_pulse_ms        (out_pulse_ms),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Register copies
  logic [8:0]  thr_cm;
  logic [7:0]  sw_min, sw_max;
  logic [5:0]  sw_step;
  logic [15:0] sw_ivl, pre_ms, lost_ms, pat_ms;

  // Sequencer state copies
  logic        m_prealarm, m_alarm, sweep_up, dual_high, servo_down;
  logic [31:0] seen_t, pre_start_t, beep_t, pat_t, sound_t, servo_t;
  logic [11:0] beep_hz, sweep_hz;
  logic [9:0]  beep_gap_ms;
  logic [1:0]  pattern;
  logic [7:0]  servo_deg;

  alarm_result_t pending_results[$];
  alarm_result_t want_r;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int input_stalls = 0;
  int tone_seen[8];
  int send_idle_pct = 25;
  int recv_idle_pct = 76;
  int gap_scale_ms = 150;
  logic [31:0] now_t = 32'h0001_0000;
  logic target_near = 1'b0;
  logic hold_active = 1'b0;
  event hold_start;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] then_t);
    return now - then_t;
  endfunction

  function automatic alarm_result_t tone(input logic [2:0] cmd, input logic [11:0] f,
                                         input logic [11:0] fa, input logic [5:0] p);
    alarm_result_t r;
    r = '0;
    r.cmd = cmd;
    r.freq = f;
    r.freq_after = fa;
    r.pulse = p;
    return r;
  endfunction

  task automatic reset_model();
    thr_cm = 9'd25; sw_min = 8'd30; sw_max = 8'd150; sw_step = 6'd2;
    sw_ivl = 16'd25; pre_ms = 16'd4000; lost_ms = 16'd1500; pat_ms = 16'd5000;
    m_prealarm = 1'b0; m_alarm = 1'b0;
    seen_t = '0; pre_start_t = '0; beep_t = '0; pat_t = '0; sound_t = '0; servo_t = '0;
    beep_hz = 12'd3200; beep_gap_ms = 10'd600;
    pattern = PAT_SWEEP; sweep_hz = 12'd2600; sweep_up = 1'b1; dual_high = 1'b1;
    servo_deg = 8'd90; servo_down = 1'b0;
  endtask

  // Works out the results of one accepted item and queues them
  task automatic predict_alarm(input logic [31:0] now, input logic [14:0] echo);
    alarm_result_t res [3];
    int n, k, dist_cm, a;
    logic led, moved;
    logic [31:0] quiet;
    n = 0;
    moved = 1'b0;
    dist_cm = int'(echo) * 17 / 1000;

    // detection
    if (echo != 0 && dist_cm > 0 && dist_cm < int'(thr_cm)) begin
      seen_t = now;
      if (!m_prealarm && !m_alarm) begin
        m_prealarm = 1'b1;
        pre_start_t = now;
        beep_hz = 12'd3200;
        beep_gap_ms = 10'd600;
      end
    end
    led = m_prealarm || m_alarm;

    // pre-alarm beeps, then escalation
    if (m_prealarm) begin
      if (ms_since(now, beep_t) > beep_gap_ms) begin
        res[n] = tone(TONE_BEEP, beep_hz, 12'd0, 6'd60);
        n++;
        if (beep_hz > 900) beep_hz -= 12'd200;
        if (beep_gap_ms > 120) beep_gap_ms -= 10'd60;
        beep_t = now;
      end
      if (ms_since(now, pre_start_t) > pre_ms) begin
        m_prealarm = 1'b0;
        m_alarm = 1'b1;
        pattern = PAT_SWEEP;
        pat_t = now;
        sweep_hz = 12'd2600;
        sweep_up = 1'b1;
      end
    end

    // siren
    if (m_alarm) begin
      if (ms_since(now, pat_t) > pat_ms) begin
        pattern = (pattern == PAT_DUAL) ? PAT_SWEEP : pattern + 2'd1;
        pat_t = now;
      end
      quiet = ms_since(now, sound_t);
      if (pattern == PAT_SWEEP && quiet > 40) begin
        sweep_hz = sweep_up ? sweep_hz + 12'd140 : sweep_hz - 12'd140;
        if (sweep_hz >= 3800) sweep_up = 1'b0;
        if (sweep_hz <= 2200) sweep_up = 1'b1;
        res[n] = tone(TONE_PLAY, sweep_hz, 12'd0, 6'd0);
        n++;
        sound_t = now;
      end else if (pattern == PAT_CHIRP && quiet > 120) begin
        res[n] = tone(TONE_TWO, 12'd3500, 12'd900, 6'd20);
        n++;
        sound_t = now;
      end else if (pattern == PAT_DUAL && quiet > 80) begin
        res[n] = tone(TONE_PLAY, dual_high ? 12'd3600 : 12'd2400, 12'd0, 6'd0);
        n++;
        dual_high = !dual_high;
        sound_t = now;
      end
    end

    // servo sweep while idle
    if (!m_prealarm && !m_alarm && ms_since(now, servo_t) > sw_ivl) begin
      a = int'(servo_deg) + (servo_down ? -int'(sw_step) : int'(sw_step));
      if (a < 0) a = 0;
      if (a > 180) a = 180;
      servo_deg = a[7:0];
      if (servo_deg >= sw_max) servo_down = 1'b1;
      if (servo_deg <= sw_min) servo_down = 1'b0;
      servo_t = now;
      moved = 1'b1;
    end

    // target lost: clear everything
    if ((m_prealarm || m_alarm) && ms_since(now, seen_t) > lost_ms) begin
      m_prealarm = 1'b0;
      m_alarm = 1'b0;
      res[n] = tone(TONE_SILENCE, 12'd0, 12'd0, 6'd0);
      n++;
    end

    if (n == 0) begin
      res[0] = tone(TONE_NONE, 12'd0, 12'd0, 6'd0);
      n = 1;
    end
    for (k = 0; k < n; k++) begin
      res[k].red = led;
      res[k].angle = servo_deg;
      res[k].moved = moved;
      res[k].last = (k == n - 1);
      pending_results.push_back(res[k]);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("%0t ns result %0d: %s", $time, results_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Compare each popped result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item waiting for it");
      end else begin
        want_r = pending_results.pop_front();
        check_field("red_led", 12'(out_red_led), 12'(want_r.red));
        check_field("servo_angle", 12'(out_servo_angle), 12'(want_r.angle));
        check_field("servo_moved", 12'(out_servo_moved), 12'(want_r.moved));
        check_field("tone_cmd", 12'(out_tone_cmd), 12'(want_r.cmd));
        check_field("tone_freq", out_tone_freq, want_r.freq);
        check_field("tone_freq_after", out_tone_freq_after, want_r.freq_after);
        check_field("pulse_ms", 12'(out_pulse_ms), 12'(want_r.pulse));
        check_field("last", 12'(out_last), 12'(want_r.last));
        tone_seen[want_r.cmd]++;
      end
      results_checked++;
    end
    if (rst_n && push && full) input_stalls++;
  end

  // Receiver: random pops, none during a hold-off
  always @(posedge clk) begin
    if (hold_active) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_start);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one item; push stays high on return so back-to-back items need no drop
  task automatic send_item(input logic [31:0] now, input logic [14:0] echo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_now_ms <= now;
    in_echo_us <= echo;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    predict_alarm(now, echo);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  thr_cm = val[8:0];
      CFG_SWEEP_MIN:  sw_min = val[7:0];
      CFG_SWEEP_MAX:  sw_max = val[7:0];
      CFG_SWEEP_STEP: sw_step = val[5:0];
      CFG_SWEEP_IVL:  sw_ivl = val;
      CFG_PREALARM:   pre_ms = val;
      CFG_LOST:       lost_ms = val;
      CFG_PATTERN:    pat_ms = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- random content

  function automatic logic [31:0] next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, gap_scale_ms);
    if (r < 92) return $urandom_range(gap_scale_ms, 4 * gap_scale_ms);
    if (r < 98) return $urandom_range(1000, 70000);
    return $urandom;  // far jump, usually wraps the clock
  endfunction

  // Echo that lands inside the detection window
  function automatic logic [14:0] near_echo();
    int hi;
    hi = (int'(thr_cm) * 1000 - 1) / 17;
    if (hi > 32767) hi = 32767;
    if (hi < 59) return 15'($urandom_range(59, 1500));  // window empty, nothing can trip
    return 15'($urandom_range(59, hi));
  endfunction

  // No echo, too close to measure, random, or beyond the threshold
  function automatic logic [14:0] noise_echo();
    int lo;
    lo = (int'(thr_cm) * 1000 + 16) / 17;
    if (lo > 32767) lo = 32767;
    case ($urandom_range(0, 3))
      0: return 15'd0;
      1: return 15'($urandom_range(0, 58));
      2: return 15'($urandom);
      default: return 15'($urandom_range(lo, 32767));
    endcase
  endfunction

  // Target comes and goes in bursts so pre-alarms and sirens actually develop
  task automatic run_episode(input int n);
    int k;
    logic [14:0] e;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 12) target_near = !target_near;
      now_t = now_t + next_gap();
      if (target_near) e = ($urandom_range(0, 99) < 85) ? near_echo() : noise_echo();
      else e = ($urandom_range(0, 99) < 8) ? near_echo() : noise_echo();
      send_item(now_t, e);
    end
  endtask

  // New register set, written only once the block is idle
  task automatic pick_settings();
    int r;
    r = $urandom_range(0, 99);
    drain();
    if (r < 60) begin
      // short timings so every stage is reached within a few items
      write_reg(CFG_THRESHOLD, 16'($urandom_range(10, 425)));
      write_reg(CFG_SWEEP_MIN, 16'($urandom_range(0, 180)));
      write_reg(CFG_SWEEP_MAX, 16'($urandom_range(0, 180)));
      write_reg(CFG_SWEEP_STEP, 16'($urandom_range(1, 45)));
      write_reg(CFG_SWEEP_IVL, 16'($urandom_range(0, 60)));
      write_reg(CFG_PREALARM, 16'($urandom_range(0, 800)));
      write_reg(CFG_LOST, 16'($urandom_range(50, 600)));
      write_reg(CFG_PATTERN, 16'($urandom_range(0, 400)));
      gap_scale_ms = 150;
    end else if (r < 73) begin
      // low extremes
      write_reg(CFG_THRESHOLD, 16'd1);
      write_reg(CFG_SWEEP_MIN, 16'd0);
      write_reg(CFG_SWEEP_MAX, 16'd0);
      write_reg(CFG_SWEEP_STEP, 16'd1);
      write_reg(CFG_SWEEP_IVL, 16'd0);
      write_reg(CFG_PREALARM, 16'd0);
      write_reg(CFG_LOST, 16'd0);
      write_reg(CFG_PATTERN, 16'd0);
      gap_scale_ms = 40;
    end else if (r < 86) begin
      // high extremes: long pre-alarm lets the beep decay bottom out
      write_reg(CFG_THRESHOLD, 16'd425);
      write_reg(CFG_SWEEP_MIN, 16'd180);
      write_reg(CFG_SWEEP_MAX, 16'd180);
      write_reg(CFG_SWEEP_STEP, 16'd45);
      write_reg(CFG_SWEEP_IVL, 16'd65535);
      write_reg(CFG_PREALARM, 16'd65535);
      write_reg(CFG_LOST, 16'd65535);
      write_reg(CFG_PATTERN, 16'd65535);
      gap_scale_ms = 700;
    end else begin
      // raw bus values, upper bits dropped by the block
      write_reg(CFG_THRESHOLD, 16'($urandom));
      write_reg(CFG_SWEEP_MIN, 16'($urandom));
      write_reg(CFG_SWEEP_MAX, 16'($urandom));
      write_reg(CFG_SWEEP_STEP, 16'($urandom));
      write_reg(CFG_SWEEP_IVL, 16'($urandom));
      write_reg(CFG_PREALARM, 16'($urandom));
      write_reg(CFG_LOST, 16'($urandom));
      write_reg(CFG_PATTERN, 16'($urandom));
      gap_scale_ms = 2000;
    end
    if ($urandom_range(0, 99) < 30)
      write_reg(4'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // No echo, echo too short to give a distance, and two echoes beyond the threshold
  task automatic test_echo_ranges();
    send_item(32'd0, 15'd0);
    send_item(32'd100, 15'd58);
    send_item(32'd200, 15'd32767);
    send_item(32'd300, 15'd25000);
  endtask

  // Detection, shrinking beeps, siren start, then loss of target
  task automatic test_prealarm_escalation();
    send_item(32'd400, 15'd1470);
    send_item(32'd1100, 15'd59);
    send_item(32'd1700, 15'd1471);
    send_item(32'd4500, 15'd1000);
    send_item(32'd6100, 15'd0);
  endtask

  // Siren cycles sweep, chirp and two-tone with a short pattern time
  task automatic test_siren_patterns();
    int k;
    drain();
    write_reg(CFG_PREALARM, 16'd0);
    write_reg(CFG_PATTERN, 16'd100);
    send_item(32'd7000, 15'd1000);
    send_item(32'd7001, 15'd1000);
    for (k = 1; k <= 5; k++) send_item(32'd7000 + 150 * k, 15'd1000);
    send_item(32'd20000, 15'd0);
  endtask

  // Beep, siren switch, siren tone and clearing all in one item
  task automatic test_event_chain();
    drain();
    write_reg(CFG_PREALARM, 16'd4000);
    write_reg(CFG_PATTERN, 16'd5000);
    send_item(32'd30000, 15'd1000);
    send_item(32'd40000, 15'd0);
  endtask

  // Timestamps crossing the 32-bit wrap
  task automatic test_time_wrap();
    send_item(32'hFFFF_FF00, 15'd1000);
    send_item(32'h0000_0040, 15'd1000);
    send_item(32'h0000_0900, 15'd0);
  endtask

  // Clamping at the ends, limits beyond 180, zero step, unused indexes
  task automatic test_servo_limits();
    drain();
    write_reg(CFG_SWEEP_STEP, 16'd45);
    write_reg(CFG_SWEEP_MIN, 16'd0);
    write_reg(CFG_SWEEP_MAX, 16'd180);
    write_reg(CFG_SWEEP_IVL, 16'd0);
    send_item(32'h0000_1000, 15'd0);
    send_item(32'h0000_1001, 15'd0);
    send_item(32'h0000_1002, 15'd0);
    drain();
    write_reg(CFG_SWEEP_STEP, 16'd0);
    write_reg(CFG_SWEEP_MIN, 16'd200);
    write_reg(CFG_SWEEP_MAX, 16'd250);
    write_reg(CFG_UNUSED_HI, 16'hFFFF);
    write_reg(CFG_UNUSED_LO, 16'h0000);
    send_item(32'h0000_1010, 15'd0);
    send_item(32'h0000_1020, 15'd0);
  endtask

  // Random episodes under one idling mix
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int ep;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (ep = 0; ep < 4; ep++) begin
      pick_settings();
      run_episode(30);
    end
  endtask

  // Receiver holds off while the sender keeps pushing, so the block fills up
  task automatic test_backpressure();
    send_idle_pct = 0;
    -> hold_start;
    run_episode(24);
    drain();
    run_episode(6);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int w;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_echo_ranges();
    test_prealarm_escalation();
    test_siren_patterns();
    test_event_chain();
    test_time_wrap();
    test_servo_limits();
    test_random_traffic(25, 76);
    test_random_traffic(76, 25);
    test_random_traffic(0, 0);
    test_backpressure();

    // wind down
    push <= 1'b0;
    for (w = 0; w < 50000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("covered %0d items, %0d results, %0d register writes, %0d input stall cycles",
             items_sent, results_checked, reg_writes, input_stalls);
    $display("tone commands: none %0d, play %0d, beep %0d, tone pair %0d, silence %0d",
             tone_seen[TONE_NONE], tone_seen[TONE_PLAY], tone_seen[TONE_BEEP],
             tone_seen[TONE_TWO], tone_seen[TONE_SILENCE]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
design/iasq_pkg.sv
design/iasq_queue.sv
design/iasq_front.sv
design/iasq_back.sv
design/intrusion_alarm_sequencer_core.sv
bench/testbench.sv
